// File: rtl/calru_pkg.sv
`timescale 1ns / 1ps

package calru_pkg;

  localparam int MAX_SETS = 1024;
  localparam int MAX_WAYS = 16;

  localparam int SET_W     = $clog2(MAX_SETS);
  localparam int WAY_W     = $clog2(MAX_WAYS);
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int ADDR_W    = 64;
  localparam int TAG_W     = 63;
  localparam int AGE_W     = 4;
  localparam int CNT_W     = 32;
  localparam int SB_W      = 4;
  localparam int OB_W      = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int SHIFT_W   = 7;

  typedef logic [SET_W-1:0]  set_idx_t;
  typedef logic [WAY_W-1:0]  way_idx_t;
  typedef logic [WCNT_W-1:0] way_cnt_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [AGE_W-1:0]  age_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
    age_t age;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  // lookup summary handed from the compare stage to the update stage
  typedef struct packed {
    logic     hit;
    way_idx_t hit_way;
    age_t     hit_age;
    logic     fill;
    way_idx_t fill_way;
    way_idx_t victim_way;
  } look_t;

  function automatic age_t age_inc(input age_t a);
    age_t r;
    r = (a == '1) ? a : a + age_t'(1);
    return r;
  endfunction

  function automatic cnt_t sat_inc(input cnt_t v);
    cnt_t r;
    r = (v == '1) ? v : v + cnt_t'(1);
    return r;
  endfunction

endpackage

// File: rtl/set_assoc_cache_lru_model_unit.sv
`timescale 1ns / 1ps

// a request's row is read on acceptance, looked up in S_LOOK and, in S_UPD, written
// back with its result registered once the output is free, while a new one may enter
// back-to-back requests to the same set are served by forwarding the written row
// reset: synchronous active-low; totals and config go to reset values, then a clearing
// pass zeroes every set row while input stays stalled

module set_assoc_cache_lru_model_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [calru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [calru_pkg::CFG_W-1:0]   cfg_wdata,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [calru_pkg::ADDR_W-1:0]  in_address,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_was_hit,
  output logic                          out_was_evicted,
  output logic [calru_pkg::CNT_W-1:0]   out_hits_so_far,
  output logic [calru_pkg::CNT_W-1:0]   out_misses_so_far,
  output logic [calru_pkg::CNT_W-1:0]   out_evictions_so_far
);
  import calru_pkg::*;

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_LOOK = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t   state_r, state_nxt;
  set_idx_t clr_idx_r, clr_idx_nxt;

  // configuration registers
  logic [SB_W-1:0]   set_bits_r;
  logic [OB_W-1:0]   offset_bits_r;
  way_cnt_t          ways_r;

  // effective configuration after clamping
  logic [SB_W-1:0]    sb_eff;
  logic [OB_W-1:0]    ob_eff;
  way_cnt_t           ways_eff;
  logic [SHIFT_W-1:0] shift_sum;
  logic [ADDR_W-1:0]  addr_sh;
  logic [ADDR_W-1:0]  tag_full;
  set_idx_t           set_in;
  tag_t               tag_in;

  // per-request context
  set_idx_t set_r;
  tag_t     tag_r;
  logic     fwd_r;
  row_t     fwd_row_r;
  row_t     row_r;
  look_t    look_r;

  row_t     rd_row;
  row_t     cur_row;
  look_t    look_c;
  row_t     new_row;

  logic     accept;
  logic     load_out;
  logic     ram_we;
  set_idx_t ram_waddr;
  row_t     ram_wdata;

  // totals and output register
  cnt_t hit_tot_r, miss_tot_r, evict_tot_r;
  cnt_t hit_tot_nxt, miss_tot_nxt, evict_tot_nxt;
  logic out_valid_r;
  logic out_hit_r, out_evict_r;
  logic res_evict;

  // config writes are taken in any state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= SB_W'(4);
      offset_bits_r <= OB_W'(4);
      ways_r        <= way_cnt_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:    set_bits_r    <= cfg_wdata[SB_W-1:0];
        CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata[OB_W-1:0];
        CFG_WAYS_IN_USE: ways_r        <= cfg_wdata[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp set bits to the index width, offset to at least one, ways to 1..MAX_WAYS
  always_comb begin
    sb_eff   = (set_bits_r > SB_W'(SET_W)) ? SB_W'(SET_W) : set_bits_r;
    ob_eff   = (offset_bits_r == '0) ? OB_W'(1) : offset_bits_r;
    if (ways_r == '0) begin
      ways_eff = way_cnt_t'(1);
    end else if (ways_r > way_cnt_t'(MAX_WAYS)) begin
      ways_eff = way_cnt_t'(MAX_WAYS);
    end else begin
      ways_eff = ways_r;
    end
    shift_sum = SHIFT_W'(sb_eff) + SHIFT_W'(ob_eff);
  end

  // address split: set index above the offset, tag above the set index
  always_comb begin
    addr_sh  = in_address >> ob_eff;
    set_in   = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
    tag_full = in_address >> shift_sum;
    tag_in   = (shift_sum >= SHIFT_W'(ADDR_W)) ? '0 : tag_full[TAG_W-1:0];
  end

  // handshake: a new request enters when idle, or while the previous one retires
  assign load_out = (state_r == S_UPD) && (!out_valid_r || !out_stall);
  assign in_stall = !((state_r == S_IDLE) || load_out);
  assign accept   = in_valid && !in_stall;

  // write port: clearing pass or write-back of the updated row
  always_comb begin
    if (state_r == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else begin
      ram_we    = load_out;
      ram_waddr = set_r;
      ram_wdata = new_row;
    end
  end

  calru_tag_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (set_in),
    .rdata (rd_row)
  );

  // the ram read missed a write-back to the same set in that cycle
  assign cur_row = fwd_r ? fwd_row_r : rd_row;

  calru_lookup u_lookup (
    .row_i  (cur_row),
    .tag_i  (tag_r),
    .ways_i (ways_eff),
    .look_o (look_c)
  );

  calru_update u_update (
    .row_i  (row_r),
    .look_i (look_r),
    .tag_i  (tag_r),
    .ways_i (ways_eff),
    .row_o  (new_row)
  );

  assign res_evict = !look_r.hit && !look_r.fill;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      S_CLR: begin
        clr_idx_nxt = clr_idx_r + set_idx_t'(1);
        if (clr_idx_r == set_idx_t'(MAX_SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end else if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // saturating totals, bumped as the result is loaded
  always_comb begin
    hit_tot_nxt   = hit_tot_r;
    miss_tot_nxt  = miss_tot_r;
    evict_tot_nxt = evict_tot_r;
    if (load_out) begin
      if (look_r.hit) begin
        hit_tot_nxt = sat_inc(hit_tot_r);
      end else begin
        miss_tot_nxt = sat_inc(miss_tot_r);
      end
      if (res_evict) begin
        evict_tot_nxt = sat_inc(evict_tot_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      hit_tot_r   <= '0;
      miss_tot_r  <= '0;
      evict_tot_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      hit_tot_r   <= hit_tot_nxt;
      miss_tot_r  <= miss_tot_nxt;
      evict_tot_r <= evict_tot_nxt;
      if (accept) begin
        fwd_r <= load_out && (set_in == set_r);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      set_r     <= set_in;
      tag_r     <= tag_in;
      fwd_row_r <= new_row;
    end
    if (state_r == S_LOOK) begin
      row_r  <= cur_row;
      look_r <= look_c;
    end
    if (load_out) begin
      out_hit_r   <= look_r.hit;
      out_evict_r <= res_evict;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_was_hit          = out_hit_r;
  assign out_was_evicted      = out_evict_r;
  assign out_hits_so_far      = hit_tot_r;
  assign out_misses_so_far    = miss_tot_r;
  assign out_evictions_so_far = evict_tot_r;

endmodule

// File: rtl/calru_tag_ram.sv
`timescale 1ns / 1ps

module calru_tag_ram (
  input  logic               clk,
  input  logic               we,
  input  calru_pkg::set_idx_t waddr,
  input  calru_pkg::row_t    wdata,
  input  logic               re,
  input  calru_pkg::set_idx_t raddr,
  output calru_pkg::row_t    rdata
);
  import calru_pkg::*;

  row_t   mem [MAX_SETS];
  row_t   rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/calru_lookup.sv
`timescale 1ns / 1ps

module calru_lookup (
  input  calru_pkg::row_t     row_i,
  input  calru_pkg::tag_t     tag_i,
  input  calru_pkg::way_cnt_t ways_i,
  output calru_pkg::look_t    look_o
);
  import calru_pkg::*;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] empty;

  way_idx_t nd_way [WAY_W+1][MAX_WAYS];
  age_t     nd_age [WAY_W+1][MAX_WAYS];
  logic     nd_use [WAY_W+1][MAX_WAYS];

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = way_cnt_t'(w) < ways_i;
      match[w]  = in_use[w] && row_i[w].valid && (row_i[w].tag == tag_i);
      empty[w]  = in_use[w] && !row_i[w].valid;
    end
  end

  // lowest matching way and lowest empty way
  always_comb begin
    look_o.hit      = |match;
    look_o.fill     = |empty;
    look_o.hit_way  = '0;
    look_o.fill_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        look_o.hit_way = way_idx_t'(w);
      end
      if (empty[w]) begin
        look_o.fill_way = way_idx_t'(w);
      end
    end
    look_o.hit_age    = row_i[look_o.hit_way].age;
    look_o.victim_way = nd_way[WAY_W][0];
  end

  // oldest in-use way, ties go to the higher way
  always_comb begin
    for (int l = 0; l <= WAY_W; l++) begin
      for (int k = 0; k < MAX_WAYS; k++) begin
        nd_way[l][k] = '0;
        nd_age[l][k] = '0;
        nd_use[l][k] = 1'b0;
      end
    end
    for (int k = 0; k < MAX_WAYS; k++) begin
      nd_way[0][k] = way_idx_t'(k);
      nd_age[0][k] = row_i[k].age;
      nd_use[0][k] = in_use[k];
    end
    for (int l = 0; l < WAY_W; l++) begin
      for (int k = 0; k < (MAX_WAYS >> (l + 1)); k++) begin
        if (nd_use[l][2*k+1] &&
            (!nd_use[l][2*k] || nd_age[l][2*k+1] >= nd_age[l][2*k])) begin
          nd_way[l+1][k] = nd_way[l][2*k+1];
          nd_age[l+1][k] = nd_age[l][2*k+1];
        end else begin
          nd_way[l+1][k] = nd_way[l][2*k];
          nd_age[l+1][k] = nd_age[l][2*k];
        end
        nd_use[l+1][k] = nd_use[l][2*k] || nd_use[l][2*k+1];
      end
    end
  end

endmodule

// File: rtl/calru_update.sv
`timescale 1ns / 1ps

module calru_update (
  input  calru_pkg::row_t     row_i,
  input  calru_pkg::look_t    look_i,
  input  calru_pkg::tag_t     tag_i,
  input  calru_pkg::way_cnt_t ways_i,
  output calru_pkg::row_t     row_o
);
  import calru_pkg::*;

  always_comb begin
    row_o = row_i;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if ((way_cnt_t'(w) < ways_i) && row_i[w].valid) begin
        if (!look_i.hit || (row_i[w].age < look_i.hit_age)) begin
          row_o[w].age = age_inc(row_i[w].age);
        end
      end
    end
    if (look_i.hit) begin
      row_o[look_i.hit_way].age = '0;
    end else if (look_i.fill) begin
      row_o[look_i.fill_way].valid = 1'b1;
      row_o[look_i.fill_way].tag   = tag_i;
      row_o[look_i.fill_way].age   = '0;
    end else begin
      row_o[look_i.victim_way].tag = tag_i;
      row_o[look_i.victim_way].age = '0;
    end
  end

endmodule

// File: rtl/calru_checker.sv
`timescale 1ns / 1ps

module calru_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_was_hit,
  input logic                            out_was_evicted,
  input logic [calru_pkg::CNT_W-1:0]     out_hits_so_far,
  input logic [calru_pkg::CNT_W-1:0]     out_misses_so_far,
  input logic [calru_pkg::CNT_W-1:0]     out_evictions_so_far
);

  // reset starts the clearing pass with nothing pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (in_stall && !out_valid))
    else $error("request taken or result shown right after reset");

  // a fresh result is loaded from S_UPD after its request passed S_LOOK, and is seen at the output once registered
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result without a matching earlier request");

  // flags agree with the totals
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |->
      ((out_was_hit ? (out_hits_so_far != '0) : (out_misses_so_far != '0)) &&
       (!out_was_evicted || (!out_was_hit && out_evictions_so_far != '0))))
    else $error("result flags disagree with totals");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_was_hit) && $stable(out_was_evicted) &&
       $stable(out_hits_so_far) && $stable(out_misses_so_far) &&
       $stable(out_evictions_so_far)))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru_model_unit calru_checker u_calru_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_was_hit          (out_was_hit),
  .out_was_evicted      (out_was_evicted),
  .out_hits_so_far      (out_hits_so_far),
  .out_misses_so_far    (out_misses_so_far),
  .out_evictions_so_far (out_evictions_so_far)
);

// File: verif/tb_set_assoc_cache_lru_model_unit.sv
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_model_unit;
  import calru_pkg::*;

  // run is killed once the cycle count passes this limit
  localparam int LIMIT_CYCLES = 1000000;
  localparam int LINES = MAX_SETS * MAX_WAYS;
  localparam int RANDOM_PHASES = 9;
  localparam int REQS_PER_PHASE = 125;
  // cfg index with no register behind it, the write must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct {
    logic hit;
    logic evicted;
    cnt_t hits;
    cnt_t misses;
    cnt_t evictions;
  } outcome_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADDR_W-1:0]    in_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_was_hit;
  logic                 out_was_evicted;
  cnt_t                 out_hits_so_far;
  cnt_t                 out_misses_so_far;
  cnt_t                 out_evictions_so_far;

  set_assoc_cache_lru_model_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_address           (in_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_was_hit          (out_was_hit),
    .out_was_evicted      (out_was_evicted),
    .out_hits_so_far      (out_hits_so_far),
    .out_misses_so_far    (out_misses_so_far),
    .out_evictions_so_far (out_evictions_so_far)
  );

  // shadow copy of the tag store, its registers and its totals
  bit   line_valid_m [LINES];
  tag_t line_tag_m   [LINES];
  age_t line_age_m   [LINES];
  cnt_t hit_count_m = '0;
  cnt_t miss_count_m = '0;
  cnt_t evict_count_m = '0;
  logic [SB_W-1:0] set_bits_m = 4'd4;
  logic [OB_W-1:0] offset_bits_m = 6'd4;
  logic [4:0]      ways_m = 5'd1;

  // one entry per accepted request, oldest first
  outcome_t lookup_results_q[$];

  int  fail_count = 0;
  int  cycles = 0;
  // no gaps on either side while set
  bit  quiet = 1'b0;
  int  stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout, %0d results still pending", $time, lookup_results_q.size());
      $display("** set_assoc_cache_lru_model_unit: FAILED **");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // set bits clipped so the set count fits, offset 0 read as 1, ways clamped
  function automatic int eff_set_bits();
    int sb;
    sb = set_bits_m;
    while (sb > 0 && (1 << sb) > MAX_SETS) sb--;
    return sb;
  endfunction

  function automatic int eff_offset_bits();
    return (offset_bits_m == 0) ? 1 : int'(offset_bits_m);
  endfunction

  function automatic int eff_ways();
    if (ways_m == 0) return 1;
    if (ways_m > MAX_WAYS) return MAX_WAYS;
    return ways_m;
  endfunction

  function automatic age_t bump_age(input age_t a);
    return (a == 4'hF) ? a : a + 4'd1;
  endfunction

  function automatic cnt_t bump_total(input cnt_t v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // lru lookup and update of the shadow store, queues the expected result
  task automatic predict_lookup(input logic [ADDR_W-1:0] addr);
    int sb, ob, ways, shift, set, base, w, j, victim, hit_way;
    tag_t tag;
    age_t hit_age, max_age;
    outcome_t o;
    sb = eff_set_bits();
    ob = eff_offset_bits();
    ways = eff_ways();
    set = int'((addr >> ob) & ((64'd1 << sb) - 64'd1));
    shift = sb + ob;
    // wide shift leaves no tag bits
    tag = (shift >= 64) ? '0 : tag_t'(addr >> shift);
    base = set * MAX_WAYS;
    o.hit = 1'b0;
    o.evicted = 1'b0;
    hit_way = 0;
    // lowest matching way wins when tags are duplicated
    for (w = 0; w < ways; w++) begin
      if (!o.hit && line_valid_m[base + w] && line_tag_m[base + w] == tag) begin
        o.hit = 1'b1;
        hit_way = w;
      end
    end
    if (o.hit) begin
      hit_age = line_age_m[base + hit_way];
      for (j = 0; j < ways; j++)
        if (line_valid_m[base + j] && line_age_m[base + j] < hit_age)
          line_age_m[base + j] = bump_age(line_age_m[base + j]);
      line_age_m[base + hit_way] = '0;
      hit_count_m = bump_total(hit_count_m);
    end else begin
      miss_count_m = bump_total(miss_count_m);
      victim = 0;
      max_age = '0;
      j = 0;
      // >= so the highest of equally old ways is the victim
      while (j < ways && line_valid_m[base + j]) begin
        if (line_age_m[base + j] >= max_age) begin
          victim = j;
          max_age = line_age_m[base + j];
        end
        j++;
      end
      if (j != ways) begin
        for (w = 0; w < ways; w++)
          if (line_valid_m[base + w]) line_age_m[base + w] = bump_age(line_age_m[base + w]);
        line_valid_m[base + j] = 1'b1;
        line_tag_m[base + j] = tag;
        line_age_m[base + j] = '0;
      end else begin
        o.evicted = 1'b1;
        evict_count_m = bump_total(evict_count_m);
        for (w = 0; w < ways; w++) line_age_m[base + w] = bump_age(line_age_m[base + w]);
        line_tag_m[base + victim] = tag;
        line_age_m[base + victim] = '0;
      end
    end
    o.hits = hit_count_m;
    o.misses = miss_count_m;
    o.evictions = evict_count_m;
    lookup_results_q.push_back(o);
  endtask

  // always entered and left just after a rising edge; valid stays up across back-to-back requests
  task automatic send_request(input logic [ADDR_W-1:0] addr);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_lookup(addr);
  endtask

  // wait for every pending result, then idle with valid low before returning
  task automatic drain();
    in_valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SET_BITS:    set_bits_m = data[SB_W-1:0];
      CFG_OFFSET_BITS: offset_bits_m = data[OB_W-1:0];
      CFG_WAYS_IN_USE: ways_m = data[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int sb, input int ob, input int ways);
    write_reg(CFG_SET_BITS, CFG_W'(sb));
    write_reg(CFG_OFFSET_BITS, CFG_W'(ob));
    write_reg(CFG_WAYS_IN_USE, CFG_W'(ways));
  endtask

  // address that lands on a given tag and set under the current settings
  function automatic logic [ADDR_W-1:0] pool_address(input logic [ADDR_W-1:0] tag_val,
                                                     input int set_val);
    int sb, ob, shift;
    logic [ADDR_W-1:0] a;
    sb = eff_set_bits();
    ob = eff_offset_bits();
    shift = sb + ob;
    a = {$urandom(), $urandom()} & ((64'd1 << ob) - 64'd1);
    a = a | ((64'(set_val) & ((64'd1 << sb) - 64'd1)) << ob);
    if (shift < 64) a = a | (tag_val << shift);
    return a;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result checker
  outcome_t want_now;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (lookup_results_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual hit=%0b evict=%0b", $time,
                 out_was_hit, out_was_evicted);
        fail_count++;
      end else begin
        want_now = lookup_results_q.pop_front();
        check_field("was_hit", 32'(want_now.hit), 32'(out_was_hit));
        check_field("was_evicted", 32'(want_now.evicted), 32'(out_was_evicted));
        check_field("hits_so_far", want_now.hits, out_hits_so_far);
        check_field("misses_so_far", want_now.misses, out_misses_so_far);
        check_field("evictions_so_far", want_now.evictions, out_evictions_so_far);
      end
    end
  end

  // reset settings: 16 sets, 1 way; zero, all ones, then a repeat that must hit
  task automatic test_reset_defaults();
    send_request(64'h0);
    send_request(64'h0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF);
    send_request(64'h0);
    // same set, other tag, single way so the line is evicted
    send_request(64'h100);
    drain();
  endtask

  // fill 16 ways, shrink to 4 so old ages saturate, then evict the oldest and age on a hit
  task automatic test_age_saturation_ties();
    int t;
    set_config(0, 1, 16);
    for (t = 0; t < 16; t++) send_request(64'(t) << 1);
    drain();
    write_reg(CFG_WAYS_IN_USE, 6'd4);
    // way 0 is already at 15 and saturates, way 1 climbs to 15, way 0 goes
    send_request(64'(16) << 1);
    // hit in way 2 ages the younger lines
    send_request(64'(2) << 1);
    drain();
  endtask

  // way 0 refilled with a tag already held in way 3, lowest way must hit
  task automatic test_duplicate_tags();
    write_reg(CFG_WAYS_IN_USE, 6'd1);
    send_request(64'(3) << 1);
    drain();
    write_reg(CFG_WAYS_IN_USE, 6'd4);
    send_request(64'(3) << 1);
    drain();
  endtask

  // clipped set bits, zero offset, zero ways, wide tag shift, write to a missing register
  task automatic test_config_extremes();
    set_config(15, 0, 0);
    send_request(64'hA5A5_5A5A_0F0F_F0F0);
    send_request(64'hA5A5_5A5A_0F0F_F0F0);
    drain();
    write_reg(CFG_OFFSET_BITS, 6'd63);
    send_request(64'h0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    write_reg(CFG_UNUSED_IDX, 6'h3F);
    send_request(64'h0);
    drain();
  endtask

  // phases of well-formed traffic on a small tag pool, with some raw noise
  task automatic test_random_traffic();
    int sb_tbl [RANDOM_PHASES] = '{2, 0, 10, 3, 1, 15, 6, 0, 0};
    int ob_tbl [RANDOM_PHASES] = '{4, 1, 6, 5, 32, 0, 58, 0, 0};
    int way_tbl[RANDOM_PHASES] = '{4, 16, 2, 8, 3, 31, 5, 0, 0};
    logic [ADDR_W-1:0] tag_pool[$];
    int p, n, pool_size, set_span;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p >= RANDOM_PHASES - 2)
        set_config($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 31));
      else
        set_config(sb_tbl[p], ob_tbl[p], way_tbl[p]);
      quiet = (p == 2 || p == 6);
      // a few more tags than ways keeps hits and evictions both common
      pool_size = eff_ways() + $urandom_range(0, 3);
      set_span = $urandom_range(0, 3);
      tag_pool.delete();
      for (n = 0; n < pool_size; n++)
        tag_pool.push_back({$urandom(), $urandom()} & 64'(($urandom_range(0, 1) ? 8'hFF : 8'h0F)));
      for (n = 0; n < REQS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 15)
          send_request({$urandom(), $urandom()});
        else
          send_request(pool_address(tag_pool[$urandom_range(0, pool_size - 1)],
                                    $urandom_range(0, set_span)));
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_age_saturation_ties();
    test_duplicate_tags();
    test_config_extremes();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && lookup_results_q.size() == 0) begin
      $display("** set_assoc_cache_lru_model_unit: PASSED **");
    end else begin
      $display("** set_assoc_cache_lru_model_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/calru_pkg.sv
rtl/calru_tag_ram.sv
rtl/calru_lookup.sv
rtl/calru_update.sv
rtl/set_assoc_cache_lru_model_unit.sv
rtl/calru_checker.sv
verif/tb_set_assoc_cache_lru_model_unit.sv
